// ===== hw/rtl/b64enc_pkg.sv =====
// Shared types, constants and symbol mapping for the Base64 stream encoder.
`timescale 1ns / 1ps
package b64enc_pkg;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 8;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CFG_INDEX_W-1:0] CFG_SYMBOL_62 = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SYMBOL_63 = 1'b1;

  localparam logic [7:0] SYMBOL_62_RESET = 8'd43;
  localparam logic [7:0] SYMBOL_63_RESET = 8'd47;

  localparam logic [5:0] SIX_62 = 6'd62;
  localparam logic [5:0] SIX_63 = 6'd63;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_message;
  } in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       run_last;
    logic       message_last;
  } out_t;

  typedef struct packed {
    logic [7:0] symbol_for_62;
    logic [7:0] symbol_for_63;
  } cfg_t;

  // one accepted byte, classified: one or two six-bit values to emit
  typedef struct packed {
    logic [5:0] first;
    logic [5:0] second;
    logic       two;
    logic       eom;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic [1:0] group_phase;
  } front_status_t;

  function automatic logic [7:0] map_symbol(input logic [5:0] v, input cfg_t cfg);
    logic [7:0] c;
    if (v < 6'd26) begin
      c = 8'd65 + {2'b00, v};
    end else if (v < 6'd52) begin
      c = 8'd97 + {2'b00, v - 6'd26};
    end else if (v < SIX_62) begin
      c = 8'd48 + {2'b00, v - 6'd52};
    end else if (v == SIX_62) begin
      c = cfg.symbol_for_62;
    end else begin
      c = cfg.symbol_for_63;
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/b64enc_front.sv =====
// Front stage: tracks group position and splits each byte into six-bit values.
`timescale 1ns / 1ps
module b64enc_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  input  b64enc_pkg::in_t           item,
  output b64enc_pkg::job_t          job,
  output b64enc_pkg::front_status_t status
);

  logic [1:0] group_phase;
  logic [5:0] leftover_bits;
  logic [1:0] group_phase_next;
  logic [5:0] leftover_bits_next;
  logic [5:0] keep;

  always_comb begin
    job.eom  = item.end_of_message;
    job.two  = 1'b0;
    keep     = 6'd0;
    job.first  = 6'd0;
    job.second = 6'd0;
    group_phase_next   = 2'd0;
    leftover_bits_next = 6'd0;
    unique case (group_phase)
      2'd2: begin
        job.first  = leftover_bits | {4'd0, item.data_byte[7:6]};
        job.second = item.data_byte[5:0];
        job.two    = 1'b1;
      end
      2'd1: begin
        job.first = leftover_bits | {2'd0, item.data_byte[7:4]};
        keep      = {item.data_byte[3:0], 2'b00};
        group_phase_next = 2'd2;
      end
      default: begin
        // phase three cannot arise; handled as start of group
        job.first = item.data_byte[7:2];
        keep      = {item.data_byte[1:0], 4'b0000};
        group_phase_next = 2'd1;
      end
    endcase
    if (group_phase != 2'd2) begin
      if (item.end_of_message) begin
        // flush partial group with zero fill
        job.second = keep;
        job.two    = 1'b1;
        group_phase_next = 2'd0;
      end else begin
        leftover_bits_next = keep;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      group_phase   <= 2'd0;
      leftover_bits <= 6'd0;
    end else if (push) begin
      group_phase   <= group_phase_next;
      leftover_bits <= leftover_bits_next;
    end
  end

  assign status.group_phase = group_phase;

endmodule

// ===== hw/rtl/b64enc_queue.sv =====
// Short FIFO between the front and back stages.
`timescale 1ns / 1ps
module b64enc_queue #(
  parameter int WIDTH = 14,
  parameter int DEPTH = b64enc_pkg::QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  logic [WIDTH-1:0]      wdata,
  input  logic                  pop,
  output logic [WIDTH-1:0]      rdata,
  output b64enc_pkg::q_status_t status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign status.full  = (count == FULL_CNT);
  assign status.empty = (count == '0);
  assign rdata        = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/b64enc_back.sv =====
// Back stage: emits one mapped character per cycle into the output register while dst is not stalled.
`timescale 1ns / 1ps
module b64enc_back (
  input  logic                  clk,
  input  logic                  rst,
  input  b64enc_pkg::cfg_t      cfg,
  input  b64enc_pkg::job_t      job,
  input  logic                  job_ready,
  output logic                  pop,
  output logic                  dst_valid,
  input  logic                  dst_stall,
  output b64enc_pkg::out_t      dst_data
);

  logic       half;
  logic       load;
  logic       last_of_job;
  logic [5:0] sel;

  assign load        = !dst_valid || !dst_stall;
  assign last_of_job = !job.two || half;
  assign sel         = half ? job.second : job.first;
  assign pop         = load && job_ready && last_of_job;

  always_ff @(posedge clk) begin
    if (rst) begin
      dst_valid <= 1'b0;
      half      <= 1'b0;
    end else if (load) begin
      dst_valid <= job_ready;
      if (job_ready) begin
        half <= !last_of_job;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && job_ready) begin
      dst_data.out_char     <= b64enc_pkg::map_symbol(sel, cfg);
      dst_data.run_last     <= last_of_job;
      dst_data.message_last <= half && job.eom;
    end
  end

endmodule

// ===== hw/rtl/base64_stream_encoder_unit.sv =====
// Top level of the unpadded Base64 stream encoder.
// A byte goes into the queue; the back stage then registers its characters on dst.
// Throughput: one character per cycle while dst is not stalled, so one byte per cycle
//   for one-character bytes; a two-character byte holds the back stage for both
//   characters. The single output register of the back stage sets this.
// Reset (rst, synchronous): group phase and leftover bits cleared, queue empty,
//   output invalid, symbol registers back to '+' and '/'.
`timescale 1ns / 1ps
module base64_stream_encoder_unit #(
  parameter int QUEUE_DEPTH = b64enc_pkg::QUEUE_DEPTH
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               src_valid,
  output logic                               src_stall,
  input  b64enc_pkg::in_t                    src_data,
  output logic                               dst_valid,
  input  logic                               dst_stall,
  output b64enc_pkg::out_t                   dst_data,
  input  logic                               cfg_we,
  input  logic [b64enc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [b64enc_pkg::CFG_DATA_W-1:0]  cfg_data
);

  b64enc_pkg::cfg_t          cfg;
  b64enc_pkg::job_t          front_job;
  b64enc_pkg::job_t          back_job;
  b64enc_pkg::q_status_t     q_status;
  b64enc_pkg::front_status_t front_status;
  logic                      push;
  logic                      pop;

  // Symbol registers; write them only while the pipe is drained (the block does not enforce this).
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.symbol_for_62 <= b64enc_pkg::SYMBOL_62_RESET;
      cfg.symbol_for_63 <= b64enc_pkg::SYMBOL_63_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        b64enc_pkg::CFG_SYMBOL_62: cfg.symbol_for_62 <= cfg_data;
        b64enc_pkg::CFG_SYMBOL_63: cfg.symbol_for_63 <= cfg_data;
        default: ;
      endcase
    end
  end

  // Front takes a transfer whenever the queue has room.
  assign src_stall = q_status.full;
  assign push      = src_valid && !src_stall;

  b64enc_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .item   (src_data),
    .job    (front_job),
    .status (front_status)
  );

  b64enc_queue #(
    .WIDTH ($bits(b64enc_pkg::job_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wdata  (front_job),
    .pop    (pop),
    .rdata  (back_job),
    .status (q_status)
  );

  // Back drains one character per cycle unless dst stalls; pops as it loads a job's last character.
  b64enc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .job       (back_job),
    .job_ready (!q_status.empty),
    .pop       (pop),
    .dst_valid (dst_valid),
    .dst_stall (dst_stall),
    .dst_data  (dst_data)
  );

  // End of message always closes the character run of its byte.
  a_msg_last_run_last: assert property (@(posedge clk) disable iff (rst)
    dst_valid && dst_data.message_last |-> dst_data.run_last)
    else $error("message_last without run_last");

  // A final byte returns the group to its start.
  a_eom_phase: assert property (@(posedge clk) disable iff (rst)
    push && src_data.end_of_message |=> front_status.group_phase == 2'd0)
    else $error("group phase not cleared after end of message");

  // Queue is never popped while empty.
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_status.empty)
    else $error("queue pop while empty");

  // Queue cannot look full and empty at once.
  a_queue_status: assert property (@(posedge clk) disable iff (rst)
    !(q_status.full && q_status.empty))
    else $error("queue full and empty together");

endmodule
